@@ sv/assert_macros.svh @@
// Assertion macros shared by the formatter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ sv/i2a_pkg.sv @@
package i2a_pkg;

    localparam int VALUE_W  = 64;
    localparam int MAG_W    = 32;
    localparam int COUNT_W  = 31;
    localparam int NDIG_W   = 5;
    localparam int BCD_W    = 40;
    localparam int BITCNT_W = 5;

    localparam logic [1:0] OP_SIGNED   = 2'd0;
    localparam logic [1:0] OP_UNSIGNED = 2'd1;
    localparam logic [1:0] OP_HEX_LO   = 2'd2;
    localparam logic [1:0] OP_HEX_UP   = 2'd3;

    localparam logic [NDIG_W-1:0]   NDIG_HEX = 5'd16;
    localparam logic [NDIG_W-1:0]   NDIG_DEC = 5'd10;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = 31'h7FFF_FFFF;
    localparam logic [BITCNT_W-1:0] BIT_LAST  = 5'd31;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_A_LO  = 8'h57;  // 'a' - 10
    localparam logic [7:0] CHAR_A_UP  = 8'h37;  // 'A' - 10

    typedef struct packed {
        logic [1:0]         op;
        logic [VALUE_W-1:0] value;
        logic               restart_count;
    } in_word_t;

    typedef struct packed {
        logic [7:0]         character;
        logic               last;
        logic [COUNT_W-1:0] count;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_STRIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic align;
        logic strip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic is_hex;
        logic conv_last;
        logic top_zero;
        logic ndig_one;
        logic neg;
        logic out_free;
    } sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            base = CHAR_ZERO;
        end else if (upper) begin
            base = CHAR_A_UP;
        end else begin
            base = CHAR_A_LO;
        end
        return base + {4'b0000, d};
    endfunction

endpackage

@@ sv/integer_to_ascii_formatter_core.sv @@
// Integer to ASCII formatter. Each input word carries an op (signed decimal,
// unsigned decimal, lower-case hex, upper-case hex), a 64-bit value and a
// restart_count flag; the core returns the number's characters one output
// word each, most significant first, no leading zeros, '-' before a negative
// signed value, last set on the final character and count giving the
// saturating running total of characters including this one. Decimal modes
// use value[31:0]. A decimal item goes through a shift-and-add-3 converter at
// one bit per cycle, then an align step that moves the BCD digits up, then
// one strip step per leading zero dropped; a hex item skips the converter
// and the align step. Characters leave one per cycle while m_ready is high.
// A new item is taken the cycle after the previous item's last character
// enters the output register.
module integer_to_ascii_formatter_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2a_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output i2a_pkg::out_word_t  m_data
);

    i2a_pkg::cmd_t cmd;
    i2a_pkg::sts_t sts;

    i2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    i2a_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ sv/i2a_ctrl.sv @@
`include "assert_macros.svh"

module i2a_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  i2a_pkg::sts_t  sts,
    output i2a_pkg::cmd_t  cmd
);

    i2a_pkg::state_t state_reg;
    i2a_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.is_hex ? i2a_pkg::ST_STRIP : i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (sts.conv_last) begin
                    state_next = i2a_pkg::ST_ALIGN;
                end
            end
            i2a_pkg::ST_ALIGN: begin
                state_next = i2a_pkg::ST_STRIP;
            end
            i2a_pkg::ST_STRIP: begin
                if (!(sts.top_zero && !sts.ndig_one)) begin
                    state_next = sts.neg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_SIGN: begin
                if (sts.out_free) begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT: begin
                if (sts.out_free && sts.ndig_one) begin
                    state_next = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            i2a_pkg::ST_CONV: begin
                cmd.conv_step = 1'b1;
            end
            i2a_pkg::ST_ALIGN: begin
                cmd.align = 1'b1;
            end
            i2a_pkg::ST_STRIP: begin
                cmd.strip = sts.top_zero && !sts.ndig_one;
            end
            i2a_pkg::ST_SIGN: begin
                cmd.emit_sign = sts.out_free;
            end
            i2a_pkg::ST_EMIT: begin
                cmd.emit_digit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_AT(a_conv_to_align, aclk, aresetn, (state_reg == i2a_pkg::ST_CONV && sts.conv_last) |=> (state_reg == i2a_pkg::ST_ALIGN))
    `ASSERT_AT(a_sign_only_neg, aclk, aresetn, (state_reg == i2a_pkg::ST_SIGN) |-> sts.neg)

endmodule

@@ sv/i2a_dp.sv @@
`include "assert_macros.svh"

module i2a_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2a_pkg::in_word_t   s_data,
    input  i2a_pkg::cmd_t       cmd,
    output i2a_pkg::sts_t       sts,
    output logic                m_valid,
    input  logic                m_ready,
    output i2a_pkg::out_word_t  m_data
);

    logic                           upper_reg, upper_next;
    logic                           neg_reg, neg_next;
    logic [i2a_pkg::MAG_W-1:0]      bin_reg, bin_next;
    logic [i2a_pkg::VALUE_W-1:0]    digits_reg, digits_next;
    logic [i2a_pkg::NDIG_W-1:0]     ndig_reg, ndig_next;
    logic [i2a_pkg::BITCNT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic [i2a_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                           m_valid_reg, m_valid_next;
    i2a_pkg::out_word_t             m_data_reg, m_data_next;

    logic                           in_hex;
    logic                           in_neg;
    logic [i2a_pkg::MAG_W-1:0]      in_mag;
    logic [i2a_pkg::BCD_W-1:0]      bcd_adj;
    logic [i2a_pkg::COUNT_W-1:0]    count_inc;
    logic [3:0]                     top_digit;

    assign in_hex    = s_data.op[1];
    assign in_mag    = s_data.value[i2a_pkg::MAG_W-1:0];
    assign in_neg    = (s_data.op == i2a_pkg::OP_SIGNED) && in_mag[i2a_pkg::MAG_W-1];
    assign top_digit = digits_reg[i2a_pkg::VALUE_W-1 -: 4];
    assign count_inc = (count_reg == i2a_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 31'd1;

    // add 3 to every BCD digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < i2a_pkg::BCD_W / 4; i++) begin
            if (digits_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = digits_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = digits_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        upper_next   = upper_reg;
        neg_next     = neg_reg;
        bin_next     = bin_reg;
        digits_next  = digits_reg;
        ndig_next    = ndig_reg;
        bitcnt_next  = bitcnt_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cmd.load) begin
            upper_next  = (s_data.op == i2a_pkg::OP_HEX_UP);
            neg_next    = in_neg;
            bin_next    = in_neg ? (~in_mag + 32'd1) : in_mag;
            digits_next = in_hex ? s_data.value : '0;
            ndig_next   = in_hex ? i2a_pkg::NDIG_HEX : i2a_pkg::NDIG_DEC;
            bitcnt_next = '0;
            if (s_data.restart_count) begin
                count_next = '0;
            end
        end

        if (cmd.conv_step) begin
            digits_next[i2a_pkg::BCD_W-1:0] = {bcd_adj[i2a_pkg::BCD_W-2:0],
                                               bin_reg[i2a_pkg::MAG_W-1]};
            bin_next    = {bin_reg[i2a_pkg::MAG_W-2:0], 1'b0};
            bitcnt_next = bitcnt_reg + 5'd1;
        end

        // move the ten BCD digits up to the top of the digit register
        if (cmd.align) begin
            digits_next = {digits_reg[i2a_pkg::BCD_W-1:0],
                           {(i2a_pkg::VALUE_W - i2a_pkg::BCD_W){1'b0}}};
        end

        if (cmd.strip || cmd.emit_digit) begin
            digits_next = {digits_reg[i2a_pkg::VALUE_W-5:0], 4'b0000};
            ndig_next   = ndig_reg - 5'd1;
        end

        if (cmd.emit_sign) begin
            m_valid_next          = 1'b1;
            m_data_next.character = i2a_pkg::CHAR_MINUS;
            m_data_next.last      = 1'b0;
            m_data_next.count     = count_inc;
            count_next            = count_inc;
        end

        if (cmd.emit_digit) begin
            m_valid_next          = 1'b1;
            m_data_next.character = i2a_pkg::digit_char(top_digit, upper_reg);
            m_data_next.last      = (ndig_reg == 5'd1);
            m_data_next.count     = count_inc;
            count_next            = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        upper_reg  <= upper_next;
        neg_reg    <= neg_next;
        bin_reg    <= bin_next;
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
        bitcnt_reg <= bitcnt_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        sts.is_hex    = in_hex;
        sts.conv_last = (bitcnt_reg == i2a_pkg::BIT_LAST);
        sts.top_zero  = (top_digit == 4'd0);
        sts.ndig_one  = (ndig_reg == 5'd1);
        sts.neg       = neg_reg;
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_AT(a_emit_into_free_slot, aclk, aresetn, (cmd.emit_digit || cmd.emit_sign) |-> (!m_valid_reg || m_ready))
    `ASSERT_NEVER(a_emit_without_digit, aclk, aresetn, cmd.emit_digit && (ndig_reg == 5'd0))

endmodule
